// ===== rtl/pfs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the palette fade sequencer.
// No dependencies.
package pfs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;

    localparam logic [2:0] OP_WRITE_TGT = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_TICK      = 3'd2;
    localparam logic [2:0] OP_KEY       = 3'd3;
    localparam logic [2:0] OP_READ_CUR  = 3'd4;

    localparam logic [1:0] PH_FADE_IN  = 2'd0;
    localparam logic [1:0] PH_HOLD     = 2'd1;
    localparam logic [1:0] PH_FADE_OUT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_KEY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUE_TICK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CUE_EN    = 3'd5;

    localparam logic [7:0]  RST_STEP     = 8'd8;
    localparam logic [7:0]  RST_FADE_IN  = 8'd64;
    localparam logic [15:0] RST_HOLD     = 16'd60;
    localparam logic [7:0]  RST_CUE_TICK = 8'd32;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] entry_index;
        logic [7:0] target_red;
        logic [7:0] target_green;
        logic [7:0] target_blue;
    } t_in_item;

    typedef struct packed {
        logic [1:0] phase_now;
        logic       fade_done;
        logic       cue_pulse;
        logic [7:0] current_red;
        logic [7:0] current_green;
        logic [7:0] current_blue;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic       lower;
        logic [7:0] step;
    } t_upd_ctrl;

endpackage

// ===== rtl/pfs_entry_update.sv =====
`timescale 1ns / 1ps
// Per-entry color update: raise toward target or lower toward black.
// Depends on pfs_pkg.
module pfs_entry_update (
    input  pfs_pkg::t_rgb      i_cur,
    input  pfs_pkg::t_rgb      i_tgt,
    input  pfs_pkg::t_upd_ctrl i_ctrl,
    output pfs_pkg::t_rgb      o_new
);
    import pfs_pkg::*;

    function automatic logic [7:0] raise_chan(input logic [7:0] cur, input logic [7:0] tgt,
                                              input logic [7:0] step);
        logic [7:0] diff;
        diff = tgt - cur;
        if (cur < tgt) begin
            return (diff > step) ? cur + step : tgt;
        end
        return cur;
    endfunction

    function automatic logic [7:0] lower_chan(input logic [7:0] cur, input logic [7:0] step);
        return (cur > step) ? cur - step : 8'd0;
    endfunction

    always_comb begin
        if (i_ctrl.lower) begin
            o_new.red   = lower_chan(i_cur.red,   i_ctrl.step);
            o_new.green = lower_chan(i_cur.green, i_ctrl.step);
            o_new.blue  = lower_chan(i_cur.blue,  i_ctrl.step);
        end else begin
            o_new.red   = raise_chan(i_cur.red,   i_tgt.red,   i_ctrl.step);
            o_new.green = raise_chan(i_cur.green, i_tgt.green, i_ctrl.step);
            o_new.blue  = raise_chan(i_cur.blue,  i_tgt.blue,  i_ctrl.step);
        end
    end

endmodule

// ===== rtl/palette_fade_sequencer.sv =====
`timescale 1ns / 1ps
// Palette fade sequencer top level: target and current palette memories, sweep control.
// Depends on pfs_pkg and pfs_entry_update.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+------------------------------
//   in       | request   | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//   out      | result    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//   cfg      | write     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A tick in fade-in or fade-out sweeps the whole palette: one read-modify-write
// of the current palette memory per entry, through its single read and write port.
// Every other request goes straight to its result. One request is in flight at a time.
// Reset is synchronous; the current palette reads black after reset through per-entry
// valid bits, so no clearing pass is needed. A stalled result holds the block.
module palette_fade_sequencer #(
    parameter int PALETTE_ENTRIES = pfs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pfs_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pfs_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfs_pkg::*;

    localparam int         AW        = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] ENTRIES_9 = 9'(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST   = AW'(PALETTE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_TAIL   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]  r_state;
    logic [7:0]  r_step;
    logic [7:0]  r_fade_in;
    logic [15:0] r_hold;
    logic        r_hold_key;
    logic [7:0]  r_cue_tick;
    logic        r_cue_en;

    logic [1:0]  r_phase;
    logic [15:0] r_count;
    logic        r_fin;
    logic        r_cue;
    logic        r_lower;
    logic        r_any;
    logic        r_is_read;
    logic        r_idx_ok;

    logic [AW-1:0] r_sweep_addr;
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_addr;

    t_rgb r_tgt_mem [PALETTE_ENTRIES];
    t_rgb r_cur_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_cur_vld;
    t_rgb r_tgt_rd;
    t_rgb r_cur_rd;
    logic r_vld_rd;

    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          in_acc;
    logic          idx_ok;
    logic [AW-1:0] in_addr;
    logic          tgt_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          cur_re;
    logic [15:0]   cnt_inc;
    logic          out_free;
    t_rgb          s1_cur;
    t_rgb          s1_new;
    logic          s1_nz;
    t_upd_ctrl     upd_ctrl;
    t_out_item     n_out;

    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign idx_ok      = ({1'b0, i_in_data.entry_index} < ENTRIES_9);
    assign in_addr     = i_in_data.entry_index[AW-1:0];
    assign tgt_we      = in_acc && (i_in_data.operation == OP_WRITE_TGT) && idx_ok;
    assign rd_en       = (r_state == ST_SWEEP);
    assign cur_re      = rd_en || (in_acc && (i_in_data.operation == OP_READ_CUR) && idx_ok);
    assign rd_addr     = rd_en ? r_sweep_addr : in_addr;
    assign cnt_inc     = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign s1_cur   = r_vld_rd ? r_cur_rd : '0;
    assign s1_nz    = (s1_cur != '0);
    assign upd_ctrl = '{lower: r_lower, step: r_step};

    pfs_entry_update u_upd (
        .i_cur  (s1_cur),
        .i_tgt  (r_tgt_rd),
        .i_ctrl (upd_ctrl),
        .o_new  (s1_new)
    );

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[in_addr] <= '{red: i_in_data.target_red, green: i_in_data.target_green,
                                    blue: i_in_data.target_blue};
        end
        if (rd_en) begin
            r_tgt_rd <= r_tgt_mem[r_sweep_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_cur_mem[r_s1_addr] <= s1_new;
        end
        if (cur_re) begin
            r_cur_rd <= r_cur_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= '0;
            r_vld_rd  <= 1'b0;
        end else begin
            if (in_acc && (i_in_data.operation == OP_START)) begin
                r_cur_vld <= '0;
            end else if (r_s1_valid) begin
                r_cur_vld[r_s1_addr] <= 1'b1;
            end
            if (cur_re) begin
                r_vld_rd <= r_cur_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= RST_STEP;
            r_fade_in  <= RST_FADE_IN;
            r_hold     <= RST_HOLD;
            r_hold_key <= 1'b0;
            r_cue_tick <= RST_CUE_TICK;
            r_cue_en   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEP:     r_step     <= i_cfg_data[7:0];
                CFG_FADE_IN:  r_fade_in  <= i_cfg_data[7:0];
                CFG_HOLD:     r_hold     <= i_cfg_data;
                CFG_HOLD_KEY: r_hold_key <= i_cfg_data[0];
                CFG_CUE_TICK: r_cue_tick <= i_cfg_data[7:0];
                CFG_CUE_EN:   r_cue_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out.phase_now     = r_phase;
        n_out.fade_done     = r_fin;
        n_out.cue_pulse     = r_cue;
        n_out.current_red   = 8'd0;
        n_out.current_green = 8'd0;
        n_out.current_blue  = 8'd0;
        if (r_is_read && r_idx_ok && r_vld_rd) begin
            n_out.current_red   = r_cur_rd.red;
            n_out.current_green = r_cur_rd.green;
            n_out.current_blue  = r_cur_rd.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_FADE_IN;
            r_count      <= 16'd0;
            r_fin        <= 1'b0;
            r_cue        <= 1'b0;
            r_lower      <= 1'b0;
            r_any        <= 1'b0;
            r_is_read    <= 1'b0;
            r_idx_ok     <= 1'b0;
            r_sweep_addr <= '0;
            r_s1_valid   <= 1'b0;
            r_s1_addr    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_s1_valid <= rd_en;
            r_s1_addr  <= r_sweep_addr;
            if (r_s1_valid) begin
                r_any <= r_any | s1_nz;
            end
            if ((r_state == ST_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state      <= ((i_in_data.operation == OP_TICK) && !r_fin &&
                                         (r_phase != PH_HOLD)) ? ST_SWEEP : ST_RESULT;
                        r_cue        <= (i_in_data.operation == OP_TICK) && !r_fin &&
                                        (r_phase == PH_FADE_IN) && r_cue_en &&
                                        (cnt_inc == {8'd0, r_cue_tick});
                        r_is_read    <= (i_in_data.operation == OP_READ_CUR);
                        r_idx_ok     <= idx_ok;
                        r_any        <= 1'b0;
                        r_sweep_addr <= '0;
                        case (i_in_data.operation)
                            OP_START: begin
                                r_phase <= PH_FADE_IN;
                                r_count <= 16'd0;
                                r_fin   <= 1'b0;
                            end
                            OP_KEY: begin
                                if (!r_fin) begin
                                    r_phase <= PH_FADE_OUT;
                                    r_count <= 16'd0;
                                end
                            end
                            OP_TICK: begin
                                if (!r_fin) begin
                                    if (r_phase == PH_FADE_IN) begin
                                        r_lower <= 1'b0;
                                        if (cnt_inc > {8'd0, r_fade_in}) begin
                                            r_phase <= PH_HOLD;
                                            r_count <= 16'd0;
                                        end else begin
                                            r_count <= cnt_inc;
                                        end
                                    end else if (r_phase == PH_HOLD) begin
                                        if (!r_hold_key && (cnt_inc > r_hold)) begin
                                            r_phase <= PH_FADE_OUT;
                                            r_count <= 16'd0;
                                        end else begin
                                            r_count <= cnt_inc;
                                        end
                                    end else begin
                                        r_lower <= 1'b1;
                                        r_count <= 16'd0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SWEEP: begin
                    r_sweep_addr <= r_sweep_addr + AW'(1);
                    if (r_sweep_addr == LAST) begin
                        r_state <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    if (r_lower && !(r_any || s1_nz)) begin
                        r_fin <= 1'b1;
                    end
                    r_state <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RESULT) && out_free) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/sv/fade_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for palette_fade_sequencer: watches the request, result and register
// channels, predicts each status result and compares it field by field.
// Depends on pfs_pkg.
module fade_result_checker #(
    parameter int PALETTE_ENTRIES = pfs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  pfs_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  pfs_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_cues,
    output int                             o_finishes
);
    import pfs_pkg::*;

    logic [7:0]  step_cfg;
    logic [7:0]  fade_in_cfg;
    logic [15:0] hold_cfg;
    logic        hold_key_cfg;
    logic [7:0]  cue_tick_cfg;
    logic        cue_en_cfg;

    t_rgb        target_pal [PALETTE_ENTRIES];
    t_rgb        current_pal[PALETTE_ENTRIES];
    logic [1:0]  phase;
    logic [15:0] tick_count;
    logic        finished;

    t_out_item   status_due[$];

    function automatic logic [7:0] rise_toward(logic [7:0] cur, logic [7:0] tgt,
                                              logic [7:0] step);
        if (cur < tgt) begin
            return (tgt - cur > step) ? cur + step : tgt;
        end
        return cur;
    endfunction

    function automatic logic [7:0] fall_by(logic [7:0] cur, logic [7:0] step);
        return (cur > step) ? cur - step : 8'd0;
    endfunction

    function automatic void restore_reset();
        step_cfg     = RST_STEP;
        fade_in_cfg  = RST_FADE_IN;
        hold_cfg     = RST_HOLD;
        hold_key_cfg = 1'b0;
        cue_tick_cfg = RST_CUE_TICK;
        cue_en_cfg   = 1'b1;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            target_pal[i]  = '0;
            current_pal[i] = '0;
        end
        phase      = PH_FADE_IN;
        tick_count = '0;
        finished   = 1'b0;
        status_due.delete();
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_STEP:     step_cfg     = val[7:0];
            CFG_FADE_IN:  fade_in_cfg  = val[7:0];
            CFG_HOLD:     hold_cfg     = val;
            CFG_HOLD_KEY: hold_key_cfg = val[0];
            CFG_CUE_TICK: cue_tick_cfg = val[7:0];
            CFG_CUE_EN:   cue_en_cfg   = val[0];
            default: ;
        endcase
    endfunction

    function automatic void advance_tick(output logic cue);
        logic black;
        cue = 1'b0;
        if (finished) begin
            return;
        end
        if (tick_count != 16'hFFFF) begin
            tick_count++;
        end
        case (phase)
            PH_FADE_IN: begin
                for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                    current_pal[i].red   = rise_toward(current_pal[i].red,
                                                       target_pal[i].red, step_cfg);
                    current_pal[i].green = rise_toward(current_pal[i].green,
                                                       target_pal[i].green, step_cfg);
                    current_pal[i].blue  = rise_toward(current_pal[i].blue,
                                                       target_pal[i].blue, step_cfg);
                end
                cue = cue_en_cfg && (tick_count == cue_tick_cfg);
                if (tick_count > fade_in_cfg) begin
                    phase      = PH_HOLD;
                    tick_count = '0;
                end
            end
            PH_HOLD: begin
                if (!hold_key_cfg && tick_count > hold_cfg) begin
                    phase      = PH_FADE_OUT;
                    tick_count = '0;
                end
            end
            default: begin
                tick_count = '0;
                black      = 1'b1;
                for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                    if (current_pal[i] != '0) begin
                        black = 1'b0;
                    end
                end
                if (black) begin
                    finished = 1'b1;
                    o_finishes++;
                end else begin
                    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                        current_pal[i].red   = fall_by(current_pal[i].red, step_cfg);
                        current_pal[i].green = fall_by(current_pal[i].green, step_cfg);
                        current_pal[i].blue  = fall_by(current_pal[i].blue, step_cfg);
                    end
                end
            end
        endcase
    endfunction

    function automatic t_out_item next_status(t_in_item req);
        t_out_item res;
        t_rgb      rd;
        logic      cue;
        res = '0;
        rd  = '0;
        cue = 1'b0;
        case (req.operation)
            OP_WRITE_TGT: begin
                if (req.entry_index < PALETTE_ENTRIES) begin
                    target_pal[req.entry_index] = {req.target_red, req.target_green,
                                                   req.target_blue};
                end
            end
            OP_START: begin
                for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                    current_pal[i] = '0;
                end
                phase      = PH_FADE_IN;
                tick_count = '0;
                finished   = 1'b0;
            end
            OP_TICK: begin
                advance_tick(cue);
            end
            OP_KEY: begin
                if (!finished) begin
                    phase      = PH_FADE_OUT;
                    tick_count = '0;
                end
            end
            OP_READ_CUR: begin
                if (req.entry_index < PALETTE_ENTRIES) begin
                    rd = current_pal[req.entry_index];
                end
            end
            default: ;
        endcase
        if (cue) begin
            o_cues++;
        end
        res.phase_now     = phase;
        res.fade_done     = finished;
        res.cue_pulse     = cue;
        res.current_red   = rd.red;
        res.current_green = rd.green;
        res.current_blue  = rd.blue;
        return res;
    endfunction

    function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
        if (got === want) begin
            return 0;
        end
        $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            restore_reset();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, got %h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = status_due.pop_front();
                    o_fail_count += field_diff("phase_now", 8'(want.phase_now),
                                               8'(i_out_data.phase_now))
                                  + field_diff("fade_done", 8'(want.fade_done),
                                               8'(i_out_data.fade_done))
                                  + field_diff("cue_pulse", 8'(want.cue_pulse),
                                               8'(i_out_data.cue_pulse))
                                  + field_diff("current_red", want.current_red,
                                               i_out_data.current_red)
                                  + field_diff("current_green", want.current_green,
                                               i_out_data.current_green)
                                  + field_diff("current_blue", want.current_blue,
                                               i_out_data.current_blue);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_due.push_back(next_status(i_in_data));
            end
        end
        o_pending = status_due.size();
    end

endmodule

// ===== tb/sv/tb_palette_fade_sequencer.sv =====
`timescale 1ns / 1ps
// Testbench top for palette_fade_sequencer: clock, reset, request traffic, register
// writes, result-side stalls and the verdict. Depends on pfs_pkg and fade_result_checker.
module tb_palette_fade_sequencer;
    import pfs_pkg::*;

    localparam int N_ENTRIES   = PALETTE_ENTRIES_DEF;
    localparam int ITEM_GOAL   = 1500;
    localparam int QUIET_FROM  = 1350;
    localparam int LONG_HOLD   = 600;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_WAIT = N_ENTRIES + 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cues;
    int finishes;

    int sent;
    int settings_run;
    bit quiet;
    int long_holds_asked;
    int long_holds_done;

    int cur_step;
    int cur_fade_in;
    int cur_hold;
    int cur_hold_key;

    palette_fade_sequencer #(
        .PALETTE_ENTRIES(N_ENTRIES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    fade_result_checker #(
        .PALETTE_ENTRIES(N_ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_cues      (cues),
        .o_finishes  (finishes)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_in_item mk_req(logic [2:0] op, logic [7:0] idx, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b);
        t_in_item req;
        req.operation    = op;
        req.entry_index  = idx;
        req.target_red   = r;
        req.target_green = g;
        req.target_blue  = b;
        return req;
    endfunction

    function automatic t_in_item rand_req(logic [2:0] op);
        return mk_req(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic send_req(input t_in_item req);
        int gap;
        gap = 0;
        if (sent >= QUIET_FROM) begin
            quiet = 1'b1;
        end
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int step, input int fade_in, input int hold,
                                 input int hold_key, input int cue, input int cue_en);
        wait_drained();
        cfg_write(CFG_STEP, 16'(step));
        cfg_write(CFG_FADE_IN, 16'(fade_in));
        cfg_write(CFG_HOLD, 16'(hold));
        cfg_write(CFG_HOLD_KEY, 16'(hold_key));
        cfg_write(CFG_CUE_TICK, 16'(cue));
        cfg_write(CFG_CUE_EN, 16'(cue_en));
        cur_step     = step;
        cur_fade_in  = fade_in;
        cur_hold     = hold;
        cur_hold_key = hold_key;
        settings_run++;
    endtask

    // mostly ticks, with reads, target writes, stray keys and starts, and unknown codes
    task automatic send_mixed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            send_req(rand_req(OP_TICK));
        end else if (pick < 88) begin
            send_req(rand_req(OP_READ_CUR));
        end else if (pick < 93) begin
            send_req(rand_req(OP_WRITE_TGT));
        end else if (pick < 96) begin
            send_req(rand_req(3'($urandom_range(5, 7))));
        end else if (pick < 98) begin
            send_req(rand_req(OP_KEY));
        end else begin
            send_req(rand_req(OP_START));
        end
    endtask

    task automatic fade_run();
        int peak;
        int n_out;
        if (cur_step == 0) begin
            n_out = 3;
        end else begin
            peak  = cur_step * (cur_fade_in + 1);
            n_out = ((peak > 255) ? 255 : peak) / cur_step + 2;
        end
        send_req(rand_req(OP_START));
        repeat (cur_fade_in + 1) send_mixed();
        repeat ((cur_hold > 20) ? 20 : cur_hold + 1) send_mixed();
        if (cur_hold_key != 0 || cur_hold > 20) begin
            send_req(rand_req(OP_KEY));
        end
        repeat (n_out) send_mixed();
    endtask

    initial begin : result_sink
        int span;
        forever begin
            @(negedge i_clk);
            if (long_holds_done != long_holds_asked) begin
                long_holds_done++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                span = $urandom_range(1, 10);
                repeat (span - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                span = $urandom_range(1, 20);
                repeat (span - 1) @(negedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        t_in_item req;
        int       n_runs;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in_data        = '0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        sent             = 0;
        settings_run     = 0;
        quiet            = 1'b0;
        long_holds_asked = 0;
        long_holds_done  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(255, 2, 1, 0, 1, 1);

        // load every target entry before any fade-in tick reads them
        for (int i = 0; i < N_ENTRIES; i++) begin
            req = rand_req(OP_WRITE_TGT);
            req.entry_index = 8'(i);
            if (i == 0) begin
                {req.target_red, req.target_green, req.target_blue} = 24'hFFFFFF;
            end else if (i == N_ENTRIES - 1) begin
                {req.target_red, req.target_green, req.target_blue} = 24'h000000;
            end
            send_req(req);
        end

        send_req(mk_req(OP_START, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_READ_CUR, 8'd0, 8'hFF, 8'hFF, 8'hFF));
        send_req(mk_req(OP_READ_CUR, 8'd255, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_READ_CUR, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_READ_CUR, 8'd128, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_READ_CUR, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_KEY, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_READ_CUR, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_req(mk_req(3'd6, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(3'd7, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_req(mk_req(OP_WRITE_TGT, 8'd255, 8'hFF, 8'h00, 8'hFF));
        send_req(mk_req(OP_START, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_KEY, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
        send_req(mk_req(OP_READ_CUR, 8'd255, 8'd0, 8'd0, 8'd0));

        while (sent < ITEM_GOAL) begin
            case (settings_run)
                1: apply_setting(int'(RST_STEP), int'(RST_FADE_IN), int'(RST_HOLD), 0,
                                 int'(RST_CUE_TICK), 1);
                2: apply_setting(1, 0, 0, 0, 0, 0);
                3: apply_setting(255, 255, 65535, 0, 255, 1);
                4: apply_setting(0, 10, 5, 1, 5, 1);
                default: begin
                    apply_setting(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                              : $urandom_range(24, 255),
                                  $urandom_range(0, 12),
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 8),
                                  ($urandom_range(0, 3) == 0) ? 1 : 0,
                                  $urandom_range(0, 14),
                                  $urandom_range(0, 1));
                end
            endcase
            n_runs = (settings_run <= 5) ? 1 : $urandom_range(1, 3);
            for (int r = 0; r < n_runs; r++) begin
                if (settings_run == 2 && r == 0) begin
                    long_holds_asked++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_req(rand_req(OP_START));
                    repeat ($urandom_range(5, 30)) send_mixed();
                end else begin
                    fade_run();
                end
                if ($urandom_range(0, 2) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (SETTLE_WAIT) @(negedge i_clk);

        $display("Run covered %0d requests over %0d register settings, %0d results checked.",
                 sent, settings_run, checked);
        $display("Predicted %0d cue pulses and %0d completed fade-outs.", cues, finishes);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
